// ===== design/vrt_pkg.sv =====
package vrt_pkg;

    localparam int CELL_W              = 16;
    localparam int ORG_W               = 32;
    localparam int DIR_W               = 16;
    localparam int ID_W                = 16;
    localparam int KIND_W              = 2;
    localparam int T_W                 = 40;
    localparam int REACH_W             = 24;
    localparam int STEPS_W             = 10;
    localparam int DIST_W              = 17;
    localparam int MAG_W               = 16;
    localparam int QUO_W               = 31;
    localparam int FRAC_W              = 16;
    localparam int DIR_FRAC_W          = 14;
    localparam int PADDR_W             = 2;
    localparam int PDATA_W             = 32;
    localparam int STEPS_PER_BLOCK_DEF = 3;
    localparam int Q_DEPTH             = 2;
    localparam logic [REACH_W-1:0] MAX_REACH_RST = 24'h080000;

    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISS  = 2'd2;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    typedef struct packed {
        logic [1:0]        sign;
        logic [CELL_W-1:0] org_cell;
        logic [DIST_W-1:0] bound_dist;
        logic [MAG_W-1:0]  mag;
    } t_axis;

    typedef struct packed {
        logic              start;
        logic [ID_W-1:0]   voxel_id;
        t_axis [2:0]       axis;
    } t_cmd;

endpackage

// ===== design/vrt_in_if.sv =====
interface vrt_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic signed [vrt_pkg::ORG_W-1:0] origin_x;
    logic signed [vrt_pkg::ORG_W-1:0] origin_y;
    logic signed [vrt_pkg::ORG_W-1:0] origin_z;
    logic signed [vrt_pkg::DIR_W-1:0] dir_x;
    logic signed [vrt_pkg::DIR_W-1:0] dir_y;
    logic signed [vrt_pkg::DIR_W-1:0] dir_z;
    logic        [vrt_pkg::ID_W-1:0]  voxel_id;

    modport source (output valid, operation, origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, voxel_id, input ready);
    modport sink   (input valid, operation, origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, voxel_id, output ready);
endinterface

// ===== design/vrt_out_if.sv =====
interface vrt_out_if;
    logic                              valid;
    logic                              ready;
    logic        [vrt_pkg::KIND_W-1:0] kind;
    logic signed [vrt_pkg::CELL_W-1:0] cell_x;
    logic signed [vrt_pkg::CELL_W-1:0] cell_y;
    logic signed [vrt_pkg::CELL_W-1:0] cell_z;
    logic signed [vrt_pkg::CELL_W-1:0] prev_x;
    logic signed [vrt_pkg::CELL_W-1:0] prev_y;
    logic signed [vrt_pkg::CELL_W-1:0] prev_z;

    modport source (output valid, kind, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z,
                    input ready);
    modport sink   (input valid, kind, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z,
                    output ready);
endinterface

// ===== design/vrt_front.sv =====
module vrt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vrt_in_if.sink        i_in,
    output logic          o_push,
    output vrt_pkg::t_cmd o_cmd,
    input  logic          i_q_ready
);
    import vrt_pkg::*;

    logic                    r_valid;
    t_cmd                    r_cmd;
    t_cmd                    n_cmd;
    logic [2:0][ORG_W-1:0]   org;
    logic [2:0][DIR_W-1:0]   dir;

    assign org = {i_in.origin_z, i_in.origin_y, i_in.origin_x};
    assign dir = {i_in.dir_z, i_in.dir_y, i_in.dir_x};

    always_comb begin
        n_cmd.start    = (i_in.operation == OP_START);
        n_cmd.voxel_id = i_in.voxel_id;
        for (int a = 0; a < 3; a++) begin
            n_cmd.axis[a].org_cell = org[a][ORG_W-1:FRAC_W];
            if (dir[a] == '0) begin
                n_cmd.axis[a].sign       = SIGN_ZERO;
                n_cmd.axis[a].bound_dist = '0;
                n_cmd.axis[a].mag        = '0;
            end else if (dir[a][DIR_W-1]) begin
                n_cmd.axis[a].sign       = SIGN_NEG;
                n_cmd.axis[a].bound_dist = {1'b0, org[a][FRAC_W-1:0]};
                n_cmd.axis[a].mag        = MAG_W'(17'h10000 - {1'b0, dir[a]});
            end else begin
                n_cmd.axis[a].sign       = SIGN_POS;
                n_cmd.axis[a].bound_dist = 17'h10000 - {1'b0, org[a][FRAC_W-1:0]};
                n_cmd.axis[a].mag        = dir[a];
            end
        end
    end

    assign i_in.ready = !r_valid || i_q_ready;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// ===== design/vrt_queue.sv =====
module vrt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vrt_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output vrt_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import vrt_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push_ok) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end
endmodule

// ===== design/vrt_back.sv =====
module vrt_back #(
    parameter int STEPS_PER_BLOCK = vrt_pkg::STEPS_PER_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  vrt_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    input  logic [vrt_pkg::REACH_W-1:0] i_max_reach,
    vrt_out_if.source                   o_out
);
    import vrt_pkg::*;

    typedef enum logic [2:0] {S_FETCH, S_SETUP, S_DIV, S_STEP, S_EMIT} t_state;

    t_state                  r_state;
    logic [2:0][CELL_W-1:0]  r_cur;
    logic [2:0][CELL_W-1:0]  r_prev;
    logic [2:0][T_W-1:0]     r_next;
    logic [2:0][T_W-1:0]     r_delta;
    logic [2:0][1:0]         r_sign;
    logic [2:0][DIST_W-1:0]  r_dist;
    logic [2:0][MAG_W-1:0]   r_mag;
    logic [STEPS_W-1:0]      r_steps;
    logic                    r_active;
    logic [2:0]              r_sel;
    logic [4:0]              r_cnt;
    logic [QUO_W-1:0]        r_quo;
    logic [MAG_W:0]          r_rem;
    logic [KIND_W-1:0]       r_kind;
    logic                    r_out_valid;
    logic [KIND_W-1:0]       r_out_kind;
    logic [2:0][CELL_W-1:0]  r_out_cell;
    logic [2:0][CELL_W-1:0]  r_out_prev;

    logic [STEPS_W-1:0]      limit;
    logic [1:0]              axis;
    logic [MAG_W:0]          rem_sh;
    logic                    qbit;
    logic [MAG_W:0]          n_rem;
    logic [QUO_W-1:0]        n_quo;
    logic [1:0]              pick;
    logic [T_W:0]            sum;
    logic [T_W-1:0]          sat;
    logic [STEPS_W-1:0]      n_steps;
    logic                    out_free;

    assign limit = STEPS_W'(i_max_reach[REACH_W-1:FRAC_W]) * STEPS_W'(STEPS_PER_BLOCK);
    assign axis  = r_sel[2:1];

    assign rem_sh = {r_rem[MAG_W-1:0], r_quo[QUO_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_mag[axis]});
    assign n_rem  = qbit ? rem_sh - {1'b0, r_mag[axis]} : rem_sh;
    assign n_quo  = {r_quo[QUO_W-2:0], qbit};

    always_comb begin
        if (r_next[0] < r_next[1]) begin
            pick = (r_next[0] < r_next[2]) ? 2'd0 : 2'd2;
        end else begin
            pick = (r_next[1] < r_next[2]) ? 2'd1 : 2'd2;
        end
        sum     = {1'b0, r_next[pick]} + {1'b0, r_delta[pick]};
        sat     = sum[T_W] ? '1 : sum[T_W-1:0];
        n_steps = r_steps + 1'b1;
    end

    assign out_free  = !r_out_valid || o_out.ready;
    assign o_cmd_pop = (r_state == S_FETCH) && i_cmd_valid;

    assign o_out.valid  = r_out_valid;
    assign o_out.kind   = r_out_kind;
    assign o_out.cell_x = r_out_cell[0];
    assign o_out.cell_y = r_out_cell[1];
    assign o_out.cell_z = r_out_cell[2];
    assign o_out.prev_x = r_out_prev[0];
    assign o_out.prev_y = r_out_prev[1];
    assign o_out.prev_z = r_out_prev[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            r_cur       <= '0;
            r_prev      <= '0;
            r_next      <= '0;
            r_delta     <= '0;
            r_sign      <= '0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_FETCH: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.start) begin
                            for (int a = 0; a < 3; a++) begin
                                r_cur[a]  <= i_cmd.axis[a].org_cell;
                                r_prev[a] <= i_cmd.axis[a].org_cell;
                                r_sign[a] <= i_cmd.axis[a].sign;
                                r_dist[a] <= i_cmd.axis[a].bound_dist;
                                r_mag[a]  <= i_cmd.axis[a].mag;
                            end
                            r_steps <= '0;
                            r_sel   <= '0;
                            if (limit == '0) begin
                                r_active <= 1'b0;
                                r_kind   <= KIND_MISS;
                                r_state  <= S_EMIT;
                            end else begin
                                r_active <= 1'b1;
                                r_state  <= S_SETUP;
                            end
                        end else if (r_active) begin
                            if (i_cmd.voxel_id != '0) begin
                                r_active <= 1'b0;
                                r_kind   <= KIND_HIT;
                                r_state  <= S_EMIT;
                            end else begin
                                r_state <= S_STEP;
                            end
                        end
                    end
                end
                S_SETUP: begin
                    if (r_sign[axis] == SIGN_ZERO) begin
                        if (r_sel[0]) begin
                            r_delta[axis] <= T_W'(i_max_reach);
                        end else begin
                            r_next[axis] <= T_W'(i_max_reach);
                        end
                        if (r_sel == 3'd5) begin
                            r_kind  <= KIND_QUERY;
                            r_state <= S_EMIT;
                        end else begin
                            r_sel <= r_sel + 1'b1;
                        end
                    end else begin
                        r_quo   <= r_sel[0] ? QUO_W'(1) << (QUO_W - 1)
                                            : {r_dist[axis], DIR_FRAC_W'(0)};
                        r_rem   <= '0;
                        r_cnt   <= 5'(QUO_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        if (r_sel[0]) begin
                            r_delta[axis] <= T_W'(n_quo);
                        end else begin
                            r_next[axis] <= T_W'(n_quo);
                        end
                        if (r_sel == 3'd5) begin
                            r_kind  <= KIND_QUERY;
                            r_state <= S_EMIT;
                        end else begin
                            r_sel   <= r_sel + 1'b1;
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_STEP: begin
                    r_prev       <= r_cur;
                    r_cur[pick]  <= r_cur[pick] + {{(CELL_W-2){r_sign[pick][1]}}, r_sign[pick]};
                    r_next[pick] <= sat;
                    r_steps      <= n_steps;
                    if (n_steps >= limit) begin
                        r_active <= 1'b0;
                        r_kind   <= KIND_MISS;
                    end else begin
                        r_kind <= KIND_QUERY;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_cell  <= (r_kind == KIND_MISS) ? '0 : r_cur;
                        r_out_prev  <= (r_kind == KIND_MISS) ? '0 : r_prev;
                        r_state     <= S_FETCH;
                    end
                end
                default: r_state <= S_FETCH;
            endcase
        end
    end
endmodule

// ===== design/voxel_ray_traversal_unit.sv =====
// A start item takes six setup passes (next and delta time per axis) through the shared
// bit-serial divider of the back-end sequencer; a zero-direction axis skips the division.
// Answers and hits need no division. The back end takes a new item only after it has
// finished the last one.
// Input stage and 2-entry queue keep accepting while the back end works.
// Reset (synchronous, active low): ray idle, cells and times zero, max_reach = 8.0 blocks.
module voxel_ray_traversal_unit #(
    parameter int STEPS_PER_BLOCK = vrt_pkg::STEPS_PER_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vrt_in_if.sink                      i_in,
    vrt_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vrt_pkg::PADDR_W-1:0] paddr,
    input  logic [vrt_pkg::PDATA_W-1:0] pwdata,
    output logic [vrt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import vrt_pkg::*;

    logic [REACH_W-1:0] r_max_reach;
    logic               push;
    t_cmd               front_cmd;
    logic               q_ready;
    logic               q_valid;
    t_cmd               q_cmd;
    logic               pop;

    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? PDATA_W'(r_max_reach) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_reach <= MAX_REACH_RST;
        end else if (psel && penable && pwrite && pready) begin
            r_max_reach <= pwdata[REACH_W-1:0];
        end
    end

    vrt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_push   (push),
        .o_cmd    (front_cmd),
        .i_q_ready(q_ready)
    );

    vrt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_cmd  (q_cmd),
        .i_pop  (pop)
    );

    vrt_back #(
        .STEPS_PER_BLOCK(STEPS_PER_BLOCK)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (pop),
        .i_max_reach(r_max_reach),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.kind == KIND_MISS |->
            o_out.cell_x == '0 && o_out.cell_y == '0 && o_out.cell_z == '0 &&
            o_out.prev_x == '0 && o_out.prev_y == '0 && o_out.prev_z == '0)
        else $error("miss carries nonzero cells");
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.kind != KIND_MISS |->
            $countones({o_out.cell_x != o_out.prev_x, o_out.cell_y != o_out.prev_y,
                        o_out.cell_z != o_out.prev_z}) <= 1)
        else $error("cell moved on more than one axis");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.kind == KIND_QUERY || o_out.kind == KIND_HIT ||
                        o_out.kind == KIND_MISS)
        else $error("bad result kind");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
`endif
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import vrt_pkg::*;

    localparam int STEPS_PER_BLOCK = STEPS_PER_BLOCK_DEF;
    localparam logic [PADDR_W-1:0] REG_MAX_REACH = 2'd0;
    localparam int IDLE_PCT = 11;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic              op;
        logic [ORG_W-1:0]  org[3];
        logic [DIR_W-1:0]  dir[3];
        logic [ID_W-1:0]   id;
    } ray_cmd_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CELL_W-1:0] cur[3];
        logic [CELL_W-1:0] prev[3];
    } walk_result_t;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    vrt_in_if  in_ch();
    vrt_out_if out_ch();

    voxel_ray_traversal_unit #(.STEPS_PER_BLOCK(STEPS_PER_BLOCK)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // walker state mirror
    logic [REACH_W-1:0] reach;
    logic [CELL_W-1:0]  cur_cell[3];
    logic [CELL_W-1:0]  prev_cell[3];
    logic [T_W-1:0]     t_next[3];
    logic [T_W-1:0]     t_delta[3];
    int                 step_dir[3];
    logic [STEPS_W-1:0] steps_done;
    bit                 walking;

    walk_result_t expected_results[$];
    int  errors = 0;
    int  n_starts = 0, n_answers = 0;
    int  n_kind[3] = '{0, 0, 0};
    int  sent = 0;
    int  hold_left = 0;
    bit  no_gaps = 0;

    initial begin
        i_clk = 0;
    end
    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int step_limit();
        return int'(reach[23:16]) * STEPS_PER_BLOCK;
    endfunction

    function automatic void setup_axis(int a, logic [ORG_W-1:0] o, logic [DIR_W-1:0] d);
        logic [63:0] mag;
        logic [63:0] gap;
        cur_cell[a] = o[31:16];
        prev_cell[a] = o[31:16];
        if (d == 0) begin
            step_dir[a] = 0;
            t_next[a] = T_W'(reach);
            t_delta[a] = T_W'(reach);
            return;
        end
        if (d[15]) begin
            step_dir[a] = -1;
            mag = 64'h10000 - 64'(d);
            gap = 64'(o[15:0]);
        end else begin
            step_dir[a] = 1;
            mag = 64'(d);
            gap = 64'h10000 - 64'(o[15:0]);
        end
        t_next[a] = T_W'((gap << 14) / mag);
        t_delta[a] = T_W'((64'd1 << 30) / mag);
    endfunction

    function automatic void fill_result(output walk_result_t r, input logic [KIND_W-1:0] k,
                                        input bit with_cells);
        r.kind = k;
        for (int i = 0; i < 3; i++) begin
            r.cur[i] = with_cells ? cur_cell[i] : '0;
            r.prev[i] = with_cells ? prev_cell[i] : '0;
        end
    endfunction

    function automatic bit predict_walk(input ray_cmd_t c, output walk_result_t r);
        int a;
        logic [63:0] sum;
        if (c.op == OP_START) begin
            for (int i = 0; i < 3; i++) setup_axis(i, c.org[i], c.dir[i]);
            steps_done = '0;
            walking = (step_limit() != 0);
            fill_result(r, walking ? KIND_QUERY : KIND_MISS, walking);
            return 1;
        end
        if (!walking) return 0;
        if (c.id != 0) begin
            walking = 0;
            fill_result(r, KIND_HIT, 1);
            return 1;
        end
        for (int i = 0; i < 3; i++) prev_cell[i] = cur_cell[i];
        if (t_next[0] < t_next[1]) a = (t_next[0] < t_next[2]) ? 0 : 2;
        else a = (t_next[1] < t_next[2]) ? 1 : 2;
        cur_cell[a] = cur_cell[a] + CELL_W'(step_dir[a]);
        sum = 64'(t_next[a]) + 64'(t_delta[a]);
        t_next[a] = (sum > 64'hFF_FFFF_FFFF) ? '1 : T_W'(sum);
        steps_done = steps_done + 1'b1;
        if (int'(steps_done) >= step_limit()) begin
            walking = 0;
            fill_result(r, KIND_MISS, 0);
        end else begin
            fill_result(r, KIND_QUERY, 1);
        end
        return 1;
    endfunction

    task automatic send_item(input ray_cmd_t c);
        walk_result_t r;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= c.op;
        in_ch.origin_x  <= c.org[0];
        in_ch.origin_y  <= c.org[1];
        in_ch.origin_z  <= c.org[2];
        in_ch.dir_x     <= c.dir[0];
        in_ch.dir_y     <= c.dir[1];
        in_ch.dir_z     <= c.dir[2];
        in_ch.voxel_id  <= c.id;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        if (c.op == OP_START) n_starts++;
        else n_answers++;
        if (predict_walk(c, r)) expected_results.push_back(r);
        if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic ray_cmd_t noise_cmd();
        ray_cmd_t c;
        c.op = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++) begin
            c.org[i] = $urandom;
            c.dir[i] = 16'($urandom);
        end
        c.id = 16'($urandom);
        return c;
    endfunction

    function automatic ray_cmd_t start_cmd();
        ray_cmd_t c;
        int pick;
        c = noise_cmd();
        c.op = OP_START;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(1)) c.org[i] = {16'($signed($urandom_range(16)) - 8),
                                               16'($urandom)};
            pick = $urandom_range(99);
            if (pick < 15) c.dir[i] = '0;
            else if (pick < 20) c.dir[i] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            else if (pick < 22) c.dir[i] = 16'h8000;
            else if (pick < 25) c.dir[i] = $urandom_range(1) ? 16'd1 : 16'hFFFF;
            else c.dir[i] = 16'($signed($urandom_range(32768)) - 16384);
        end
        return c;
    endfunction

    function automatic ray_cmd_t answer_cmd(logic [ID_W-1:0] id);
        ray_cmd_t c;
        c = noise_cmd();
        c.op = OP_ANSWER;
        c.id = id;
        return c;
    endfunction

    task automatic cfg_write(input logic [PADDR_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= idx;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_REACH) reach = val[REACH_W-1:0];
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reach(input logic [PDATA_W-1:0] val);
        wait_idle();
        cfg_write(REG_MAX_REACH, val);
    endtask

    task automatic walk_rays(input int n_items);
        int stop_at, k;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                send_item(noise_cmd());
            end else begin
                send_item(start_cmd());
                k = $urandom_range(0, (step_limit() + 2 > 40) ? 40 : step_limit() + 2);
                repeat (k) send_item(answer_cmd('0));
                if ($urandom_range(1)) send_item(answer_cmd(16'($urandom_range(1, 65535))));
            end
        end
    endtask

    task automatic test_directed();
        ray_cmd_t c;
        send_item(answer_cmd(16'hFFFF));
        c = start_cmd();
        c.org = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
        c.dir = '{16'sd16384, -16'sd16384, 16'h0000};
        c.id = 16'hFFFF;
        send_item(c);
        repeat (4) send_item(answer_cmd('0));
        send_item(answer_cmd(16'h0001));
        c.org = '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000};
        c.dir = '{16'd9459, 16'd9459, 16'd9459};
        send_item(c);
        repeat (3) send_item(answer_cmd('0));
        send_item(answer_cmd(16'hFFFF));
        c.org = '{32'hFFFF_0000, 32'h0001_FFFF, 32'h8000_FFFF};
        c.dir = '{16'h8000, 16'h0001, 16'hFFFF};
        send_item(c);
        repeat (3) send_item(answer_cmd('0));
        c.dir = '{16'h0000, 16'h0000, 16'h0000};
        send_item(c);
        repeat (2) send_item(answer_cmd('0));
        send_item(answer_cmd(16'h8000));
    endtask

    task automatic test_zero_limit();
        set_reach(32'h00FF_FFFF);
        set_reach(32'h0000_FFFF);
        send_item(start_cmd());
        send_item(answer_cmd('0));
        send_item(start_cmd());
        send_item(answer_cmd(16'h1234));
        set_reach(32'h0000_0000);
        walk_rays(20);
    endtask

    task automatic test_walks();
        set_reach(32'h0001_0000);
        walk_rays(400);
        set_reach(32'h0005_8000);
        no_gaps = 1;
        walk_rays(400);
        no_gaps = 0;
        set_reach(32'h00FF_FFFF);
        walk_rays(400);
        set_reach(32'h0002_0000);
        walk_rays(400);
    endtask

    task automatic test_backpressure();
        set_reach(32'h00FF_FFFF);
        hold_left = 600;
        send_item(start_cmd());
        repeat (150) send_item(answer_cmd('0));
        send_item(answer_cmd(16'h00AA));
    endtask

    always @(posedge i_clk) begin
        walk_result_t e;
        logic [CELL_W-1:0] got[7];
        logic [CELL_W-1:0] want[7];
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{CELL_W'(out_ch.kind), out_ch.cell_x, out_ch.cell_y, out_ch.cell_z,
                    out_ch.prev_x, out_ch.prev_y, out_ch.prev_z};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d cell=%0d,%0d,%0d", $time,
                         out_ch.kind, out_ch.cell_x, out_ch.cell_y, out_ch.cell_z);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (out_ch.kind < 3) n_kind[out_ch.kind]++;
                want = '{CELL_W'(e.kind), e.cur[0], e.cur[1], e.cur[2],
                         e.prev[0], e.prev[1], e.prev[2]};
                for (int f = 0; f < 7; f++) begin
                    if (got[f] !== want[f]) begin
                        $display("%0t: field %0d expected %0d actual %0d", $time, f,
                                 $signed(want[f]), $signed(got[f]));
                        errors++;
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_START;
        in_ch.origin_x = '0;
        in_ch.origin_y = '0;
        in_ch.origin_z = '0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        in_ch.dir_z = '0;
        in_ch.voxel_id = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reach = MAX_REACH_RST;
        for (int i = 0; i < 3; i++) begin
            cur_cell[i] = '0;
            prev_cell[i] = '0;
            t_next[i] = '0;
            t_delta[i] = '0;
            step_dir[i] = 0;
        end
        steps_done = '0;
        walking = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_zero_limit();
        test_walks();
        test_backpressure();
        wait_idle();

        $display("Covered %0d ray starts and %0d answers over reach limits 0 to 255 blocks;",
                 n_starts, n_answers);
        $display("checked %0d queries, %0d hits, %0d misses.", n_kind[0], n_kind[1], n_kind[2]);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
